[src/pale_pkg.sv]
// Package: sizes, field types and codes for the positional array list engine.
`timescale 1ns / 1ps

package pale_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int LEN_W    = 9;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [CMP_W-1:0]         cmp_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_REMOVE = 3'd2,
        MODE_READ   = 3'd3,
        MODE_SEARCH = 3'd4,
        MODE_CLEAR  = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_INS_PUT,
        S_RM_HEAD,
        S_SHIFT_DN,
        S_READ,
        S_SEARCH,
        S_DONE
    } state_t;

endpackage

[src/pale_req_if.sv]
// Interface: request channel of the positional array list engine.
`timescale 1ns / 1ps

interface pale_req_if;
    logic            valid;
    logic            ready;
    logic [2:0]      mode;
    pale_pkg::pos_t  position;
    pale_pkg::data_t value;

    modport source (output valid, mode, position, value, input ready);
    modport sink   (input valid, mode, position, value, output ready);
endinterface

[src/pale_rsp_if.sv]
// Interface: result channel of the positional array list engine.
`timescale 1ns / 1ps

interface pale_rsp_if;
    logic            valid;
    logic            ready;
    logic [1:0]      status;
    pale_pkg::data_t read_value;
    logic            found;
    pale_pkg::pos_t  found_position;
    pale_pkg::len_t  list_length;
    logic            is_empty;

    modport source (output valid, status, read_value, found, found_position, list_length,
                    is_empty, input ready);
    modport sink   (input valid, status, read_value, found, found_position, list_length,
                    is_empty, output ready);
endinterface

[src/positional_array_list_engine.sv]
// Top level: ordered list of signed 32-bit values in one synchronous entry memory.
// Insert and remove shift the entries from the position to the end; a search stops at the first match.
// One item at a time; the next item is taken in the cycle after the result is registered.
// The shifts and the search walk through the entry memory one entry per cycle.
// Reset (rst_n, async low) empties the list; the entry memory is not cleared.
`timescale 1ns / 1ps

module positional_array_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    pale_req_if.sink    req,
    pale_rsp_if.source  rsp
);

    pale_pkg::data_t mem [pale_pkg::CAPACITY];
    pale_pkg::data_t rdata_reg;
    logic            mem_we;
    pale_pkg::addr_t mem_waddr;
    pale_pkg::data_t mem_wdata;
    pale_pkg::addr_t mem_raddr;

    pale_pkg::state_t  state_reg, state_next;
    logic [2:0]        mode_reg;
    pale_pkg::pos_t    pos_reg;
    pale_pkg::data_t   val_reg;
    pale_pkg::cnt_t    count_reg, count_next;
    pale_pkg::addr_t   idx_reg, idx_next;
    pale_pkg::status_t st_reg, st_next;
    pale_pkg::data_t   rd_reg, rd_next;
    logic              fnd_reg, fnd_next;
    pale_pkg::addr_t   fpos_reg, fpos_next;

    logic              out_valid_reg, out_valid_next;
    pale_pkg::status_t out_status_reg;
    pale_pkg::data_t   out_read_reg;
    logic              out_found_reg;
    pale_pkg::pos_t    out_fpos_reg;
    pale_pkg::len_t    out_len_reg;
    logic              out_empty_reg;

    logic full;
    logic pos_gt;
    logic pos_eq;
    logic pos_ge;
    logic up_last;
    logic more;
    logic match;
    logic out_free;

    assign full     = count_reg >= pale_pkg::cnt_t'(pale_pkg::CAPACITY);
    assign pos_gt   = pale_pkg::cmp_t'(pos_reg) > pale_pkg::cmp_t'(count_reg);
    assign pos_eq   = pale_pkg::cmp_t'(pos_reg) == pale_pkg::cmp_t'(count_reg);
    assign pos_ge   = pos_gt || pos_eq;
    assign up_last  = idx_reg == pale_pkg::addr_t'(pos_reg);
    assign more     = (pale_pkg::cnt_t'(idx_reg) + pale_pkg::cnt_t'(1)) < count_reg;
    assign match    = rdata_reg == val_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    assign mem_raddr = idx_next;

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pale_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = pale_pkg::S_DECODE;
                end
            end
            pale_pkg::S_DECODE:
            begin
                state_next = pale_pkg::S_DONE;
                case (mode_reg)
                    pale_pkg::MODE_INSERT:
                    begin
                        if (!full && !pos_gt && !pos_eq)
                        begin
                            state_next = pale_pkg::S_SHIFT_UP;
                        end
                    end
                    pale_pkg::MODE_REMOVE:
                    begin
                        if (!pos_ge)
                        begin
                            state_next = pale_pkg::S_RM_HEAD;
                        end
                    end
                    pale_pkg::MODE_READ:
                    begin
                        if (!pos_ge)
                        begin
                            state_next = pale_pkg::S_READ;
                        end
                    end
                    pale_pkg::MODE_SEARCH:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = pale_pkg::S_SEARCH;
                        end
                    end
                    default:
                    begin
                        state_next = pale_pkg::S_DONE;
                    end
                endcase
            end
            pale_pkg::S_SHIFT_UP:
            begin
                if (up_last)
                begin
                    state_next = pale_pkg::S_INS_PUT;
                end
            end
            pale_pkg::S_INS_PUT:
            begin
                state_next = pale_pkg::S_DONE;
            end
            pale_pkg::S_RM_HEAD:
            begin
                state_next = more ? pale_pkg::S_SHIFT_DN : pale_pkg::S_DONE;
            end
            pale_pkg::S_SHIFT_DN:
            begin
                if (!more)
                begin
                    state_next = pale_pkg::S_DONE;
                end
            end
            pale_pkg::S_READ:
            begin
                state_next = pale_pkg::S_DONE;
            end
            pale_pkg::S_SEARCH:
            begin
                if (match || !more)
                begin
                    state_next = pale_pkg::S_DONE;
                end
            end
            pale_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = pale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pale_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = rdata_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        st_next    = st_reg;
        rd_next    = rd_reg;
        fnd_next   = fnd_reg;
        fpos_next  = fpos_reg;
        case (state_reg)
            pale_pkg::S_DECODE:
            begin
                st_next   = pale_pkg::ST_OK;
                rd_next   = '0;
                fnd_next  = 1'b0;
                fpos_next = '0;
                case (mode_reg)
                    pale_pkg::MODE_APPEND:
                    begin
                        if (full)
                        begin
                            st_next = pale_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = pale_pkg::addr_t'(count_reg);
                            mem_wdata  = val_reg;
                            count_next = count_reg + pale_pkg::cnt_t'(1);
                        end
                    end
                    pale_pkg::MODE_INSERT:
                    begin
                        if (full)
                        begin
                            st_next = pale_pkg::ST_FULL;
                        end
                        else if (pos_gt)
                        begin
                            st_next = pale_pkg::ST_RANGE;
                        end
                        else if (pos_eq)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = pale_pkg::addr_t'(pos_reg);
                            mem_wdata  = val_reg;
                            count_next = count_reg + pale_pkg::cnt_t'(1);
                        end
                        else
                        begin
                            idx_next = pale_pkg::addr_t'(count_reg - pale_pkg::cnt_t'(1));
                        end
                    end
                    pale_pkg::MODE_REMOVE,
                    pale_pkg::MODE_READ:
                    begin
                        if (pos_ge)
                        begin
                            st_next = pale_pkg::ST_RANGE;
                        end
                        else
                        begin
                            idx_next = pale_pkg::addr_t'(pos_reg);
                        end
                    end
                    pale_pkg::MODE_SEARCH:
                    begin
                        idx_next = '0;
                    end
                    pale_pkg::MODE_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        st_next = pale_pkg::ST_OK;
                    end
                endcase
            end
            pale_pkg::S_SHIFT_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg + pale_pkg::addr_t'(1);
                mem_wdata = rdata_reg;
                if (!up_last)
                begin
                    idx_next = idx_reg - pale_pkg::addr_t'(1);
                end
            end
            pale_pkg::S_INS_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pale_pkg::addr_t'(pos_reg);
                mem_wdata  = val_reg;
                count_next = count_reg + pale_pkg::cnt_t'(1);
            end
            pale_pkg::S_RM_HEAD:
            begin
                rd_next = rdata_reg;
                if (more)
                begin
                    idx_next = idx_reg + pale_pkg::addr_t'(1);
                end
                else
                begin
                    count_next = count_reg - pale_pkg::cnt_t'(1);
                end
            end
            pale_pkg::S_SHIFT_DN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - pale_pkg::addr_t'(1);
                mem_wdata = rdata_reg;
                if (more)
                begin
                    idx_next = idx_reg + pale_pkg::addr_t'(1);
                end
                else
                begin
                    count_next = count_reg - pale_pkg::cnt_t'(1);
                end
            end
            pale_pkg::S_READ:
            begin
                rd_next = rdata_reg;
            end
            pale_pkg::S_SEARCH:
            begin
                if (match)
                begin
                    fnd_next  = 1'b1;
                    fpos_next = idx_reg;
                end
                else if (more)
                begin
                    idx_next = idx_reg + pale_pkg::addr_t'(1);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == pale_pkg::S_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pale_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg <= req.mode;
            pos_reg  <= req.position;
            val_reg  <= req.value;
        end
        idx_reg  <= idx_next;
        st_reg   <= st_next;
        rd_reg   <= rd_next;
        fnd_reg  <= fnd_next;
        fpos_reg <= fpos_next;
        if (state_reg == pale_pkg::S_DONE && out_free)
        begin
            out_status_reg <= st_reg;
            out_read_reg   <= rd_reg;
            out_found_reg  <= fnd_reg;
            out_fpos_reg   <= pale_pkg::pos_t'(fpos_reg);
            out_len_reg    <= pale_pkg::len_t'(count_reg);
            out_empty_reg  <= count_reg == '0;
        end
    end

    assign req.ready          = state_reg == pale_pkg::S_IDLE;
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.read_value     = out_read_reg;
    assign rsp.found          = out_found_reg;
    assign rsp.found_position = out_fpos_reg;
    assign rsp.list_length    = out_len_reg;
    assign rsp.is_empty       = out_empty_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pale_pkg::cnt_t'(pale_pkg::CAPACITY))
        else $error("list length above capacity");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pale_pkg::S_IDLE |-> !mem_we)
        else $error("memory write while idle");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg == pale_pkg::S_DECODE)
        else $error("accepted item not decoded");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.status == pale_pkg::ST_OK && rsp.read_value == '0)
        else $error("found result with error status or read value");

endmodule
